// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker module of the forest code lattice ranker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/fclr_pkg.sv =====
// Package of the forest code lattice ranker: widths, codes and the shared
// adder request type. No dependencies.
`default_nettype none

package fclr_pkg;

    localparam int MAX_CODE_BITS = 62;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CNT_W         = 59;
    localparam int CFG_W         = 6;
    localparam int POS_W         = $clog2(MAX_CODE_BITS + 1);
    localparam int ADDR_W        = 2 * POS_W;
    localparam int TABLE_DEPTH   = 1 << ADDR_W;

    localparam int S_TDATA_W = ((CODE_W + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CODE_W + 2 * CNT_W + 7) / 8) * 8;

    // Register indexes of the configuration port.
    localparam logic REG_LEAF_COUNT = 1'b0;
    localparam logic REG_ROOT_COUNT = 1'b1;

    // Operation codes carried in the slave tuser.
    localparam logic OP_RANK   = 1'b0;
    localparam logic OP_UNRANK = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef logic [CNT_W:0] alu_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fclr_alu.sv =====
// Shared add/subtract unit of the forest code lattice ranker.
// Depends on fclr_pkg. The top bit of the result is the carry or the borrow.
`default_nettype none

module fclr_alu
    import fclr_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    always_comb
    begin
        if (req.sub)
        begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            res = {1'b0, req.a} + {1'b0, req.b};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/forest_code_lattice_rank_core.sv =====
// Top level of the forest code lattice ranker: sequencer, completion count
// table and output register. Depends on fclr_pkg and fclr_alu.
`default_nettype none

// The block ranks and unranks preorder bit codes of binary forests with n leaves
// and r roots (code length L = 2n - r, bit 1 ordered before bit 0). A table of
// path completion counts sits in an on-chip memory of 4096 entries of 59 bits,
// addressed by {zeros, ones}. After reset and after every configuration write
// the sequencer rebuilds the table by walking the diagonals of the lattice
// backward: an entry is written at once when it is fixed (end point or a
// prefix that cannot be a forest) and after two table reads and an add
// otherwise; s_tready stays low meanwhile. To rank or unrank an item, the
// sequencer walks over the L code positions before its result is loaded
// into the output register: each position needs one read of the count
// memory, whose address depends on the decision at the previous position,
// and one pass through the single shared 59-bit add/subtract unit. The
// block works on one item at a time; the output register lets it take the
// next transfer while a result still waits on the master side. A
// configuration with r above n, r of zero or L above 62 is flagged with
// config_invalid, and all other result fields are then zero. An unrank
// index at or beyond total_forests sets index_too_large with a zero code.
module forest_code_lattice_rank_core
    import fclr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata fields from bit 0 up: code_in[61:0], index_in[120:62], zero pad.
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0 up: operation.
    input  wire logic                 s_tuser,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata fields from bit 0 up: code_out[61:0], index_out[120:62],
    // total_forests[179:121], zero pad.
    output logic [M_TDATA_W-1:0]      m_tdata,
    // m_tuser fields from bit 0 up: index_too_large, config_invalid.
    output logic [1:0]                m_tuser
);

    localparam logic [3:0] S_RB_INIT   = 4'd0;
    localparam logic [3:0] S_RB_ENTRY  = 4'd1;
    localparam logic [3:0] S_RB_SECOND = 4'd2;
    localparam logic [3:0] S_RB_WRITE  = 4'd3;
    localparam logic [3:0] S_IDLE      = 4'd4;
    localparam logic [3:0] S_CHECK     = 4'd5;
    localparam logic [3:0] S_START     = 4'd6;
    localparam logic [3:0] S_WALK      = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    // Control registers.
    logic [3:0]       state_reg, state_next;
    logic [CFG_W-1:0] leaf_reg, leaf_next;
    logic [CFG_W-1:0] root_reg, root_next;
    logic             cfg_ok_reg, cfg_ok_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] z_reg, z_next;
    logic [POS_W-1:0] o_reg, o_next;
    logic             m_valid_reg, m_valid_next;

    // Payload registers.
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  work_reg, work_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              op_reg, op_next;
    logic              too_large_reg, too_large_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic [CNT_W-1:0]  out_index_reg, out_index_next;
    logic [CNT_W-1:0]  out_total_reg, out_total_next;
    logic              out_too_large_reg, out_too_large_next;
    logic              out_invalid_reg, out_invalid_next;

    // Count memory.
    logic [CNT_W-1:0]  count_mem [0:TABLE_DEPTH-1];
    logic [CNT_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CNT_W-1:0]  mem_wdata;

    alu_req_t alu_req;
    alu_res_t alu_res;

    // Configuration derived values.
    logic [POS_W:0]   len_wide;
    logic [POS_W-1:0] code_len;
    logic [CFG_W-1:0] k_cnt;
    logic             cfg_ok_now;

    // Rebuild helpers.
    logic [POS_W-1:0] rb_o;
    logic [POS_W-1:0] p_sel;
    logic [POS_W-1:0] z_first;
    logic [POS_W-1:0] p_dec;
    logic             ones_live;
    logic [CNT_W-1:0] ones_val;
    logic             accept;
    logic             out_free;

    fclr_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign len_wide   = {leaf_reg, 1'b0} - {1'b0, root_reg};
    assign code_len   = len_wide[POS_W-1:0];
    assign k_cnt      = leaf_reg - root_reg;
    assign cfg_ok_now = (root_reg != '0) && (root_reg <= leaf_reg)
                        && (len_wide <= (POS_W + 1)'(MAX_CODE_BITS));

    // On a diagonal p the first entry has o = min(p, k), so z starts at p - k or zero.
    assign rb_o    = p_reg - z_reg;
    assign p_dec   = p_reg - 1'b1;
    assign p_sel   = (state_reg == S_RB_INIT) ? code_len : p_dec;
    assign z_first = (p_sel > k_cnt) ? (p_sel - k_cnt) : '0;

    // A lookup past the last caret or past the last leaf reads as zero.
    assign ones_live = (o_reg < k_cnt) && (z_reg <= leaf_reg);
    assign ones_val  = ones_live ? rd_data_reg : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        unique case (state_reg)
            S_RB_WRITE:
            begin
                alu_req.a   = work_reg;
                alu_req.b   = (z_reg < leaf_reg) ? rd_data_reg : '0;
                alu_req.sub = 1'b0;
            end
            S_CHECK:
            begin
                alu_req.a   = work_reg;
                alu_req.b   = total_reg;
                alu_req.sub = 1'b1;
            end
            S_WALK:
            begin
                alu_req.a   = work_reg;
                alu_req.b   = ones_val;
                alu_req.sub = (op_reg == OP_UNRANK);
            end
            default:
            begin
                alu_req.a   = work_reg;
                alu_req.b   = '0;
                alu_req.sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next         = state_reg;
        leaf_next          = leaf_reg;
        root_next          = root_reg;
        cfg_ok_next        = cfg_ok_reg;
        p_next             = p_reg;
        z_next             = z_reg;
        o_next             = o_reg;
        m_valid_next       = m_valid_reg;
        total_next         = total_reg;
        work_next          = work_reg;
        code_next          = code_reg;
        op_next            = op_reg;
        too_large_next     = too_large_reg;
        out_code_next      = out_code_reg;
        out_index_next     = out_index_reg;
        out_total_next     = out_total_reg;
        out_too_large_next = out_too_large_reg;
        out_invalid_next   = out_invalid_reg;
        mem_we             = 1'b0;
        mem_waddr          = {z_reg, rb_o};
        mem_wdata          = alu_res[CNT_W-1:0];
        mem_raddr          = {z_reg, o_reg + 1'b1};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_RB_INIT:
            begin
                cfg_ok_next = cfg_ok_now;
                total_next  = '0;
                p_next      = code_len;
                z_next      = z_first;
                state_next  = cfg_ok_now ? S_RB_ENTRY : S_IDLE;
            end
            S_RB_ENTRY:
            begin
                if (p_reg == code_len)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = CNT_W'(1);
                end
                else if ({1'b0, z_reg} >= ({1'b0, rb_o} + {1'b0, root_reg}))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '0;
                end
                else
                begin
                    mem_raddr  = {z_reg, rb_o + 1'b1};
                    state_next = S_RB_SECOND;
                end
            end
            S_RB_SECOND:
            begin
                work_next  = (rb_o < k_cnt) ? rd_data_reg : '0;
                mem_raddr  = {z_reg + 1'b1, rb_o};
                state_next = S_RB_WRITE;
            end
            S_RB_WRITE:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = s_tuser;
                    too_large_next = 1'b0;
                    p_next         = '0;
                    z_next         = '0;
                    o_next         = '0;
                    if (s_tuser == OP_UNRANK)
                    begin
                        code_next = '0;
                        work_next = s_tdata[CODE_W +: CNT_W];
                    end
                    else
                    begin
                        code_next = s_tdata[CODE_W-1:0];
                        work_next = '0;
                    end
                    if (!cfg_ok_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (s_tuser == OP_UNRANK)
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_CHECK:
            begin
                // No borrow means the index is at or beyond the total.
                if (!alu_res[CNT_W])
                begin
                    too_large_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                mem_raddr  = {z_reg, o_reg + 1'b1};
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (op_reg == OP_UNRANK)
                begin
                    if (alu_res[CNT_W])
                    begin
                        code_next = code_reg | (CODE_W'(1) << p_reg);
                        o_next    = o_reg + 1'b1;
                    end
                    else
                    begin
                        work_next = alu_res[CNT_W-1:0];
                        z_next    = z_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!code_reg[p_reg])
                    begin
                        work_next = alu_res[CNT_W-1:0];
                        z_next    = z_reg + 1'b1;
                    end
                    else
                    begin
                        o_next = o_reg + 1'b1;
                    end
                end
                // The next position's lookup is issued from this decision.
                mem_raddr = {z_next, o_next + 1'b1};
                p_next    = p_reg + 1'b1;
                if (p_reg == code_len - 1'b1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_code_next      = (op_reg == OP_UNRANK) ? code_reg : '0;
                    out_index_next     = (op_reg == OP_UNRANK) ? '0 : work_reg;
                    out_total_next     = total_reg;
                    out_too_large_next = too_large_reg;
                    out_invalid_next   = !cfg_ok_reg;
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_RB_INIT;
            end
        endcase

        // After a table write, step to the next entry of the diagonal, down to the
        // next diagonal, or to idle after the last one.
        if (mem_we)
        begin
            if ((z_reg == '0) && (rb_o == '0))
            begin
                total_next = mem_wdata;
            end
            if ((z_reg < leaf_reg) && (z_reg < p_reg))
            begin
                z_next     = z_reg + 1'b1;
                state_next = S_RB_ENTRY;
            end
            else if (p_reg == '0)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                p_next     = p_dec;
                z_next     = z_first;
                state_next = S_RB_ENTRY;
            end
        end

        // A register write restarts the table build.
        if (cfg_wr_en)
        begin
            if (cfg_addr == REG_LEAF_COUNT)
            begin
                leaf_next = cfg_wr_data;
            end
            else
            begin
                root_next = cfg_wr_data;
            end
            state_next = S_RB_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_RB_INIT;
            leaf_reg    <= CFG_W'(2);
            root_reg    <= CFG_W'(1);
            cfg_ok_reg  <= 1'b0;
            p_reg       <= '0;
            z_reg       <= '0;
            o_reg       <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            leaf_reg    <= leaf_next;
            root_reg    <= root_next;
            cfg_ok_reg  <= cfg_ok_next;
            p_reg       <= p_next;
            z_reg       <= z_next;
            o_reg       <= o_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg         <= total_next;
        work_reg          <= work_next;
        code_reg          <= code_next;
        op_reg            <= op_next;
        too_large_reg     <= too_large_next;
        out_code_reg      <= out_code_next;
        out_index_reg     <= out_index_next;
        out_total_reg     <= out_total_next;
        out_too_large_reg <= out_too_large_next;
        out_invalid_reg   <= out_invalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= count_mem[mem_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CODE_W - 2 * CNT_W)'(0),
                       out_total_reg, out_index_reg, out_code_reg};
    assign m_tuser  = {out_invalid_reg, out_too_large_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/fclr_checker.sv =====
// Port-level checker of the forest code lattice ranker and its bind to the top.
// Depends on fclr_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module fclr_checker
    import fclr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]           m_tuser
);

    // A flagged configuration leaves every data field at zero.
    `FCLR_ASSERT_IMP(a_invalid_zero, clk, rst_n, m_tvalid && m_tuser[1], m_tdata == '0)

    // An index at or beyond the total gives neither a code nor a rank.
    `FCLR_ASSERT_IMP(a_too_large_zero, clk, rst_n, m_tvalid && m_tuser[0],
        m_tdata[CODE_W+CNT_W-1:0] == '0)

    // The two flags never come together.
    `FCLR_ASSERT_IMP(a_flags_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))

    // One item at a time: a transfer in closes the input for the next cycle.
    `FCLR_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // A stalled result holds.
    `FCLR_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind forest_code_lattice_rank_core fclr_checker u_fclr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/forest_code_lattice_rank_checker.sv =====
// Checker for the forest code lattice ranker: watches the configuration port and both
// stream channels, predicts each result and compares it field by field.
// Depends on fclr_pkg for widths and register indexes.
module forest_code_lattice_rank_checker
    import fclr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    output int                   fail_count,
    output int                   pending,
    output logic [CNT_W-1:0]     forest_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAD_LO = CODE_W + 2 * CNT_W;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  index;
        logic [CNT_W-1:0]  total;
        logic              too_large;
        logic              cfg_bad;
    } lattice_result_t;

    int              leaves;
    int              roots;
    bit              cfg_good;
    logic [CNT_W-1:0] total_paths;
    logic [CNT_W-1:0] paths_left [0:MAX_CODE_BITS][0:MAX_CODE_BITS];
    lattice_result_t awaited_results [$];

    initial fail_count = 0;

    function automatic logic [CNT_W-1:0] paths_at(int z, int o);
        if (z > MAX_CODE_BITS || o > MAX_CODE_BITS)
            return '0;
        return paths_left[z][o];
    endfunction

    // Backward pass over the lattice diagonals: each entry counts the ways a prefix
    // with z leaves and o carets can still be completed into a forest.
    task automatic refill_paths();
        int n;
        int r;
        int len;
        int k;
        int o;
        logic [63:0] v;
        for (int zi = 0; zi <= MAX_CODE_BITS; zi++)
            for (int oi = 0; oi <= MAX_CODE_BITS; oi++)
                paths_left[zi][oi] = '0;
        total_paths = '0;
        n = leaves;
        r = roots;
        cfg_good = (r >= 1) && (r <= n) && (2 * n - r <= MAX_CODE_BITS);
        if (!cfg_good)
            return;
        len = 2 * n - r;
        k = n - r;
        for (int p = len; p >= 0; p--) begin
            for (int z = 0; z <= n && z <= p; z++) begin
                o = p - z;
                if (o > k)
                    continue;
                if (p == len)
                    v = 64'd1;
                else if (z >= o + r)
                    v = 64'd0;
                else begin
                    v = 64'd0;
                    if (o < k)
                        v += {5'b0, paths_left[z][o + 1]};
                    if (z < n)
                        v += {5'b0, paths_left[z + 1][o]};
                end
                paths_left[z][o] = v[CNT_W-1:0];
            end
        end
        total_paths = paths_left[0][0];
    endtask

    function automatic lattice_result_t predict_lattice(logic op, logic [CODE_W-1:0] code,
                                                        logic [CNT_W-1:0] idx);
        lattice_result_t res;
        logic [63:0] acc;
        logic [63:0] rest;
        logic [63:0] ones;
        int len;
        int k;
        int z;
        int o;
        res = '0;
        if (!cfg_good) begin
            res.cfg_bad = 1'b1;
            return res;
        end
        res.total = total_paths;
        len = 2 * leaves - roots;
        k = leaves - roots;
        z = 0;
        o = 0;
        if (op == OP_RANK) begin
            acc = '0;
            for (int p = 0; p < len; p++) begin
                if (!code[p]) begin
                    if (o < k && z <= leaves)
                        acc += {5'b0, paths_at(z, o + 1)};
                    z++;
                end
                else
                    o++;
            end
            res.index = acc[CNT_W-1:0];
        end
        else if (idx >= total_paths)
            res.too_large = 1'b1;
        else begin
            rest = {5'b0, idx};
            for (int p = 0; p < len; p++) begin
                ones = (o < k) ? {5'b0, paths_at(z, o + 1)} : 64'd0;
                if (rest < ones) begin
                    res.code[p] = 1'b1;
                    o++;
                end
                else begin
                    rest -= ones;
                    z++;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lattice_result_t want;
        lattice_result_t got;
        logic [M_TDATA_W-PAD_LO-1:0] pad;
        if (!rst_n) begin
            leaves = 2;
            roots = 1;
            refill_paths();
            awaited_results.delete();
        end
        else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_LEAF_COUNT)
                    leaves = cfg_wr_data;
                else
                    roots = cfg_wr_data;
                refill_paths();
            end
            if (m_tvalid && m_tready) begin
                got.code      = m_tdata[0 +: CODE_W];
                got.index     = m_tdata[CODE_W +: CNT_W];
                got.total     = m_tdata[CODE_W + CNT_W +: CNT_W];
                got.too_large = m_tuser[0];
                got.cfg_bad   = m_tuser[1];
                pad           = m_tdata[M_TDATA_W-1:PAD_LO];
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: result transfer with nothing awaited, code %h index %h",
                                 got.code, got.index);
                end
                else begin
                    want = awaited_results.pop_front();
                    if (got.code !== want.code || got.index !== want.index ||
                        got.total !== want.total || got.too_large !== want.too_large ||
                        got.cfg_bad !== want.cfg_bad || pad !== '0) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"checker: mismatch code exp %h got %h, index exp %h got %h,",
                                      " total exp %h got %h, too_large exp %b got %b,",
                                      " config_invalid exp %b got %b, pad %h"},
                                     want.code, got.code, want.index, got.index,
                                     want.total, got.total, want.too_large, got.too_large,
                                     want.cfg_bad, got.cfg_bad, pad);
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_lattice(s_tuser, s_tdata[0 +: CODE_W],
                                                          s_tdata[CODE_W +: CNT_W]));
        end
        pending = awaited_results.size();
        forest_total = total_paths;
    end

endmodule

// ===== dv/forest_code_lattice_rank_core_tb.sv =====
// Testbench top of the forest code lattice ranker: clock, reset, stimulus and verdict.
// Depends on fclr_pkg, forest_code_lattice_rank_core and forest_code_lattice_rank_checker.
module forest_code_lattice_rank_core_tb
    import fclr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_addr = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    int               fail_count;
    int               pending;
    logic [CNT_W-1:0] forest_total;

    // Idle and stall odds in percent; the stimulus process changes them per phase.
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // Configuration that the stimulus currently believes in; it only steers which
    // items are generated, the checker keeps its own copy for prediction.
    int cur_leaves = 2;
    int cur_roots = 1;

    forest_code_lattice_rank_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    forest_code_lattice_rank_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .forest_total (forest_total)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // The result side stalls at random; m_tready changes only at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit cfg_is_valid(int n, int r);
        return (r >= 1) && (r <= n) && (2 * n - r <= MAX_CODE_BITS);
    endfunction

    // Builds a well-formed forest code by a random walk that never lets a proper
    // prefix reach the root count, and leaves random junk above the code length
    // since the block must ignore those bits.
    function automatic logic [CODE_W-1:0] random_forest(int n, int r);
        logic [63:0] junk;
        logic [CODE_W-1:0] c;
        int len;
        int k;
        int z;
        int o;
        bit can_one;
        bit can_zero;
        junk = rand64();
        c = junk[CODE_W-1:0];
        len = 2 * n - r;
        k = n - r;
        z = 0;
        o = 0;
        for (int p = 0; p < len; p++) begin
            can_one = (o < k);
            can_zero = (z < n) && ((z + 1 - o < r) || (p == len - 1));
            if (can_one && (!can_zero || $urandom_range(1) == 1)) begin
                c[p] = 1'b1;
                o++;
            end
            else begin
                c[p] = 1'b0;
                z++;
            end
        end
        return c;
    endfunction

    // Offers one item on the slave side and returns once its transfer has happened.
    // Data changes at the falling edge; acceptance is judged from the values that
    // stood at the rising edge, before the block updates its registers.
    task automatic send_item(logic op, logic [CODE_W-1:0] code, logic [CNT_W-1:0] idx);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = '0;
        s_tdata[0 +: CODE_W] = code;
        s_tdata[CODE_W +: CNT_W] = idx;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // The sender holds off until every awaited result has come back, so the block
    // is idle. Every item causes a result, so no extra settling time is needed.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // A register write starts a table rebuild; s_tready is low until it is done.
    task automatic write_reg(logic addr, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        while (!s_tready)
            @(negedge clk);
    endtask

    task automatic apply_config(int n, int r);
        drain_results();
        write_reg(REG_LEAF_COUNT, CFG_W'(n));
        write_reg(REG_ROOT_COUNT, CFG_W'(r));
        cur_leaves = n;
        cur_roots = r;
    endtask

    // Most configurations are small so rebuilds stay short; a few are large and a
    // few are invalid in one of its ways.
    task automatic pick_config(output int n, output int r);
        int roll;
        int r_lo;
        roll = $urandom_range(99);
        if (roll < 70) begin
            n = $urandom_range(8, 1);
            r = $urandom_range(n, 1);
        end
        else if (roll < 90) begin
            n = $urandom_range(MAX_CODE_BITS, 9);
            r_lo = (2 * n - MAX_CODE_BITS > 1) ? 2 * n - MAX_CODE_BITS : 1;
            r = $urandom_range(n, r_lo);
        end
        else begin
            case ($urandom_range(2))
                0: begin
                    n = $urandom_range(63, 0);
                    r = 0;
                end
                1: begin
                    n = $urandom_range(62, 0);
                    r = $urandom_range(63, n + 1);
                end
                default: begin
                    n = $urandom_range(63, 32);
                    r = $urandom_range(2 * n - MAX_CODE_BITS - 1, 1);
                end
            endcase
        end
    endtask

    // Random item for the current configuration: mostly well-formed codes and
    // in-range indexes, with noise codes and out-of-range indexes mixed in.
    task automatic send_random_item();
        logic [63:0] raw;
        logic [CNT_W-1:0] idx;
        int roll;
        raw = rand64();
        if (!cfg_is_valid(cur_leaves, cur_roots)) begin
            send_item(logic'($urandom_range(1)), raw[CODE_W-1:0], rand64() >> 5);
            return;
        end
        roll = $urandom_range(99);
        if (roll < 45)
            send_item(OP_RANK, random_forest(cur_leaves, cur_roots), raw[CNT_W-1:0]);
        else if (roll < 55)
            send_item(OP_RANK, raw[CODE_W-1:0], raw[63 -: CNT_W]);
        else if (roll < 90) begin
            idx = CNT_W'(raw % {5'b0, forest_total});
            send_item(OP_UNRANK, rand64() >> 2, idx);
        end
        else begin
            case ($urandom_range(2))
                0: idx = forest_total;
                1: idx = raw[CNT_W-1:0];
                default: idx = '1;
            endcase
            send_item(OP_UNRANK, rand64() >> 2, idx);
        end
    endtask

    initial
    begin
        int n;
        int r;
        int guard;
        int src_modes [4];
        int sink_modes [4];
        src_modes = '{0, 86, 0, 33};
        sink_modes = '{0, 0, 86, 33};

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        while (!s_tready)
            @(negedge clk);

        // Directed part. Reset configuration: two leaves, one root, a single forest.
        // The all-zero code is not a forest, and junk above the code length is ignored.
        send_item(OP_RANK, '0, '0);
        send_item(OP_RANK, '1, '1);
        send_item(OP_RANK, {{(CODE_W-3){1'b1}}, 3'b001}, '0);
        send_item(OP_UNRANK, '0, '0);
        send_item(OP_UNRANK, '1, CNT_W'(1));
        send_item(OP_UNRANK, '0, '1);

        // Every tree is a lone leaf: longest code, one forest, no carets at all.
        apply_config(MAX_CODE_BITS, MAX_CODE_BITS);
        send_item(OP_RANK, '0, '0);
        send_item(OP_RANK, '1, '0);
        send_item(OP_UNRANK, '0, '0);
        send_item(OP_UNRANK, '0, CNT_W'(1));

        // Single tree with the largest count that fits, then two trees at full length.
        apply_config(31, 1);
        send_item(OP_RANK, random_forest(31, 1), '0);
        send_item(OP_UNRANK, '0, forest_total - 1'b1);
        send_item(OP_UNRANK, '0, forest_total);
        send_item(OP_UNRANK, '1, '0);
        apply_config(32, 2);
        send_item(OP_RANK, random_forest(32, 2), '1);
        send_item(OP_UNRANK, '0, forest_total - 1'b1);

        // Invalid settings: code too long with all register bits set, roots of zero
        // with leaves of zero, and more roots than leaves.
        apply_config(63, 63);
        send_item(OP_RANK, random_forest(31, 1), '0);
        send_item(OP_UNRANK, '0, '0);
        apply_config(0, 0);
        send_item(OP_UNRANK, '0, '0);
        send_item(OP_RANK, '1, '1);
        apply_config(5, 6);
        send_item(OP_RANK, '0, '0);

        // Random part: four idling phases, each over a run of configurations.
        for (int mode = 0; mode < 4; mode++) begin
            drain_results();
            src_idle_pct = src_modes[mode];
            sink_stall_pct = sink_modes[mode];
            for (int c = 0; c < 8; c++) begin
                pick_config(n, r);
                apply_config(n, r);
                repeat ($urandom_range(75, 45))
                    send_random_item();
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(negedge clk);
            guard++;
        end
        // More waiting afterwards, so a stray extra result would still be caught.
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== forest_code_lattice_rank_core.f =====
+incdir+hw/rtl
hw/rtl/fclr_pkg.sv
hw/rtl/fclr_alu.sv
hw/rtl/forest_code_lattice_rank_core.sv
hw/rtl/fclr_checker.sv
dv/forest_code_lattice_rank_checker.sv
dv/forest_code_lattice_rank_core_tb.sv
